// ===== design/murmur_hash_64b_defines.svh =====
// Assertion helpers for the murmur_hash_64b block.
// MHB_ASSERT checks a condition on every rising clock edge outside reset.
// MHB_ASSERT_NEXT checks that a condition implies another in the next cycle.
`ifndef MURMUR_HASH_64B_DEFINES_SVH
`define MURMUR_HASH_64B_DEFINES_SVH

`ifndef SYNTHESIS
`define MHB_ASSERT(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define MHB_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define MHB_ASSERT(name, clk, rst, expr, msg)
`define MHB_ASSERT_NEXT(name, clk, rst, cond, expr, msg)
`endif

`endif

// ===== design/mhb_pkg.sv =====
`timescale 1ns / 1ps

package mhb_pkg;

   localparam logic [31:0] MIX_M      = 32'h5bd1_e995;
   localparam int unsigned MIX_R      = 24;
   localparam logic [31:0] SEED_RESET = 32'hEE6B_27EB;

   localparam int unsigned FIN_SHIFT_1 = 18;
   localparam int unsigned FIN_SHIFT_2 = 22;
   localparam int unsigned FIN_SHIFT_3 = 17;
   localparam int unsigned FIN_SHIFT_4 = 19;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TAIL,
      KIND_FULL
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        first;
      logic        last;
      logic [31:0] word;
      logic [31:0] length;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_port_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_MIX1,
      ST_MIX2,
      ST_FOLD,
      ST_TAIL,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_FIN4
   } back_state_type;

endpackage

// ===== design/mhb_front.sv =====
`timescale 1ns / 1ps

module mhb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_data_word,
   input  logic [2:0]              req_valid_bytes,
   input  logic                    req_first_word,
   input  logic                    req_last_word,
   input  logic [31:0]             req_total_length,
   output mhb_pkg::queue_port_type push,
   input  logic                    queue_full
);

   logic              front_valid_ff;
   logic              front_valid_in;
   mhb_pkg::item_type front_item_ff;
   mhb_pkg::item_type front_item_in;
   logic              accept;
   logic              pushed;
   logic [31:0]       tail_mask;

   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign pushed    = front_valid_ff && !queue_full;

   always_comb begin
      case (req_valid_bytes)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      front_item_in        = front_item_ff;
      front_item_in.first  = req_first_word;
      front_item_in.last   = req_last_word;
      front_item_in.length = req_total_length;
      front_item_in.word   = req_data_word & tail_mask;
      // 5..7 bytes count as a full word
      if (req_valid_bytes == 3'd0) begin
         front_item_in.kind = mhb_pkg::KIND_NONE;
      end else if (req_valid_bytes[2]) begin
         front_item_in.kind = mhb_pkg::KIND_FULL;
      end else begin
         front_item_in.kind = mhb_pkg::KIND_TAIL;
      end
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (pushed) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

   assign push.valid = front_valid_ff;
   assign push.item  = front_item_ff;

endmodule

// ===== design/mhb_queue.sv =====
`timescale 1ns / 1ps
`include "murmur_hash_64b_defines.svh"

module mhb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mhb_pkg::queue_port_type push,
   output logic                    full,
   output mhb_pkg::queue_port_type head,
   input  logic                    pop
);

   localparam int unsigned PTR_W = mhb_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = mhb_pkg::QUEUE_CNT_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mhb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mhb_pkg::QUEUE_DEPTH);

   mhb_pkg::item_type entry_ff [mhb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              write;

   assign full  = (count_ff == CNT_FULL);
   assign write = push.valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (write && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   `MHB_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_FULL, "queue count over depth")
   `MHB_ASSERT(a_no_pop_empty, clock, reset, !(pop && count_ff == '0), "pop from empty queue")

endmodule

// ===== design/mhb_back.sv =====
`timescale 1ns / 1ps
`include "murmur_hash_64b_defines.svh"

module mhb_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [31:0]             csr_seed,
   input  mhb_pkg::queue_port_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [63:0]             rsp_hash_value
);

   mhb_pkg::back_state_type state_ff;
   mhb_pkg::back_state_type state_in;
   mhb_pkg::item_type       item_ff;
   mhb_pkg::item_type       item_in;
   logic [31:0]             seed_ff;
   logic [31:0]             acc_high_ff;
   logic [31:0]             acc_high_in;
   logic [31:0]             acc_low_ff;
   logic [31:0]             acc_low_in;
   logic                    parity_ff;
   logic                    parity_in;
   logic [31:0]             k_ff;
   logic [31:0]             k_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [63:0]             rsp_hash_ff;
   logic [31:0]             mul_a;
   logic [31:0]             prod;
   logic                    out_free;
   logic                    fin_load;

   function automatic mhb_pkg::back_state_type dispatch(mhb_pkg::kind_type kind, logic last);
      mhb_pkg::back_state_type next;
      case (kind)
         mhb_pkg::KIND_FULL: next = mhb_pkg::ST_MIX1;
         mhb_pkg::KIND_TAIL: next = mhb_pkg::ST_TAIL;
         default:            next = last ? mhb_pkg::ST_FIN1 : mhb_pkg::ST_IDLE;
      endcase
      return next;
   endfunction

   // single shared constant multiplier, low 32 bits
   assign prod     = mul_a * mhb_pkg::MIX_M;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      acc_high_in = acc_high_ff;
      acc_low_in  = acc_low_ff;
      parity_in   = parity_ff;
      k_in        = k_ff;
      mul_a       = '0;
      pop         = 1'b0;
      fin_load    = 1'b0;
      case (state_ff)
         mhb_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               item_in = head.item;
               state_in = head.item.first ? mhb_pkg::ST_INIT
                                          : dispatch(head.item.kind, head.item.last);
            end
         end
         mhb_pkg::ST_INIT: begin
            acc_high_in = seed_ff ^ item_ff.length;
            acc_low_in  = '0;
            parity_in   = 1'b0;
            state_in    = dispatch(item_ff.kind, item_ff.last);
         end
         mhb_pkg::ST_MIX1: begin
            mul_a    = item_ff.word;
            k_in     = prod;
            state_in = mhb_pkg::ST_MIX2;
         end
         mhb_pkg::ST_MIX2: begin
            mul_a    = k_ff ^ (k_ff >> mhb_pkg::MIX_R);
            k_in     = prod;
            state_in = mhb_pkg::ST_FOLD;
         end
         mhb_pkg::ST_FOLD: begin
            if (!parity_ff) begin
               mul_a       = acc_high_ff;
               acc_high_in = prod ^ k_ff;
            end else begin
               mul_a      = acc_low_ff;
               acc_low_in = prod ^ k_ff;
            end
            parity_in = !parity_ff;
            state_in  = item_ff.last ? mhb_pkg::ST_FIN1 : mhb_pkg::ST_IDLE;
         end
         mhb_pkg::ST_TAIL: begin
            mul_a      = acc_low_ff ^ item_ff.word;
            acc_low_in = prod;
            state_in   = item_ff.last ? mhb_pkg::ST_FIN1 : mhb_pkg::ST_IDLE;
         end
         mhb_pkg::ST_FIN1: begin
            mul_a       = acc_high_ff ^ (acc_low_ff >> mhb_pkg::FIN_SHIFT_1);
            acc_high_in = prod;
            state_in    = mhb_pkg::ST_FIN2;
         end
         mhb_pkg::ST_FIN2: begin
            mul_a      = acc_low_ff ^ (acc_high_ff >> mhb_pkg::FIN_SHIFT_2);
            acc_low_in = prod;
            state_in   = mhb_pkg::ST_FIN3;
         end
         mhb_pkg::ST_FIN3: begin
            mul_a       = acc_high_ff ^ (acc_low_ff >> mhb_pkg::FIN_SHIFT_3);
            acc_high_in = prod;
            state_in    = mhb_pkg::ST_FIN4;
         end
         mhb_pkg::ST_FIN4: begin
            mul_a = acc_low_ff ^ (acc_high_ff >> mhb_pkg::FIN_SHIFT_4);
            // wait here while the previous result is still held
            if (out_free) begin
               fin_load    = 1'b1;
               acc_high_in = '0;
               acc_low_in  = '0;
               parity_in   = 1'b0;
               state_in    = mhb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (fin_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhb_pkg::ST_IDLE;
         seed_ff      <= mhb_pkg::SEED_RESET;
         acc_high_ff  <= '0;
         acc_low_ff   <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_high_ff  <= acc_high_in;
         acc_low_ff   <= acc_low_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            seed_ff <= csr_seed;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      k_ff    <= k_in;
      if (fin_load) begin
         rsp_hash_ff <= {acc_high_ff, prod};
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   `MHB_ASSERT_NEXT(a_fin_clears, clock, reset, fin_load, acc_high_ff == '0 && acc_low_ff == '0 && !parity_ff && rsp_valid_ff, "state not cleared after result")
   `MHB_ASSERT_NEXT(a_fin_holds, clock, reset, state_ff == mhb_pkg::ST_FIN4 && rsp_valid_ff && rsp_stall, state_ff == mhb_pkg::ST_FIN4, "finalize left while output busy")

endmodule

// ===== design/murmur_hash_64b.sv =====
`timescale 1ns / 1ps
// Channel    | Ports                                              | Handshake
// request    | req_data_word, req_valid_bytes, req_first_word,    | req_valid / req_stall
//            | req_last_word, req_total_length                    |
// response   | rsp_hash_value                                     | rsp_valid / rsp_stall
// csr        | csr_seed                                           | csr_write_en
//
// In the back end an item is dequeued; a first word then seeds the hash state, a full
// word runs MIX1, MIX2, FOLD, a tail runs TAIL, and a last word adds 4 finalize rounds;
// all steps share one 32-bit constant multiplier. A 4-entry queue plus one input register
// absorb bursts. Synchronous active-high reset clears state and loads seed 0xEE6B27EB.
// The result is held in an output register; while it is stalled, a following last word
// waits in its final round and the queue keeps taking transactions until full.

module murmur_hash_64b (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_seed,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [31:0] req_total_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);

   mhb_pkg::queue_port_type push;
   mhb_pkg::queue_port_type head;
   logic                    queue_full;
   logic                    pop;

   mhb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .push             (push),
      .queue_full       (queue_full)
   );

   mhb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mhb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_seed       (csr_seed),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 210;
   localparam int HOLD_AFTER     = 30;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        first;
      logic        last;
      logic [31:0] length;
      logic        typed;
      logic [63:0] hash;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [31:0] csr_seed;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_data_word;
   logic [2:0]  req_valid_bytes;
   logic        req_first_word;
   logic        req_last_word;
   logic [31:0] req_total_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_hash_value;

   murmur_hash_64b dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_seed         (csr_seed),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // hash state mirrored from the block
   logic [31:0] hash_seed;
   logic [31:0] acc_hi;
   logic [31:0] acc_lo;
   logic        lane_odd;
   logic [63:0] pending_hashes[$];

   int errors = 0;
   int results_seen;
   int idle_cycles;
   int send_run;
   int recv_run;

   // word, bytes, first, last, length, typed, hash
   stim_row_type directed_rows [0:19] = '{
      '{32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 64'h0},  // no first after reset
      '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, mhb_pkg::SEED_RESET, 1'b1, 64'h0},  // seed ^ length == 0
      '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 64'h0},  // empty message
      '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'h0000_0004, 1'b0, 64'h0},
      '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0000_0018, 1'b0, 64'h0},
      '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, 32'h0000_0018, 1'b0, 64'h0},  // oversize count = full
      '{32'hA5A5_A5A5, 3'd5, 1'b0, 1'b0, 32'h0000_0018, 1'b0, 64'h0},
      '{32'h1234_5678, 3'd1, 1'b0, 1'b0, 32'h0000_0018, 1'b0, 64'h0},  // short word mid-message
      '{32'hDEAD_BEEF, 3'd6, 1'b0, 1'b0, 32'h0000_0018, 1'b0, 64'h0},
      '{32'hFFFF_FFFF, 3'd3, 1'b0, 1'b1, 32'h0000_0018, 1'b0, 64'h0},  // upper byte ignored
      '{32'hCAFE_F00D, 3'd2, 1'b1, 1'b1, 32'h0000_0002, 1'b0, 64'h0},
      '{32'h8000_0001, 3'd4, 1'b0, 1'b0, 32'h0000_0008, 1'b0, 64'h0},  // starts from cleared state
      '{32'h7FFF_FFFE, 3'd4, 1'b0, 1'b1, 32'h0000_0008, 1'b0, 64'h0},
      '{32'h1122_3344, 3'd4, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0},  // length mismatch
      '{32'h5566_7788, 3'd4, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 64'h0},  // restart mid-message
      '{32'hFFFF_FFFF, 3'd1, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 64'h0},
      '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 32'h0000_000C, 1'b0, 64'h0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0000_000C, 1'b0, 64'h0},
      '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0000_000C, 1'b0, 64'h0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'h0000_000C, 1'b0, 64'h0}   // empty last, odd lane
   };

   function automatic logic [31:0] scramble(logic [31:0] k);
      k = k * mhb_pkg::MIX_M;
      k = k ^ (k >> mhb_pkg::MIX_R);
      return k * mhb_pkg::MIX_M;
   endfunction

   // returns 1 when the transaction closes a message
   function automatic bit fold_item(stim_row_type r, output logic [63:0] hash);
      logic [2:0]  n;
      logic [31:0] h1;
      logic [31:0] h2;
      n = (r.nbytes > 3'd4) ? 3'd4 : r.nbytes;
      hash = '0;
      if (r.first) begin
         acc_hi   = hash_seed ^ r.length;
         acc_lo   = '0;
         lane_odd = 1'b0;
      end
      if (n == 3'd4) begin
         if (!lane_odd) acc_hi = acc_hi * mhb_pkg::MIX_M ^ scramble(r.word);
         else acc_lo = acc_lo * mhb_pkg::MIX_M ^ scramble(r.word);
         lane_odd = ~lane_odd;
      end else if (n != 3'd0) begin
         acc_lo = (acc_lo ^ (r.word & ((32'd1 << (8 * n)) - 32'd1))) * mhb_pkg::MIX_M;
      end
      if (!r.last) return 1'b0;
      h1 = acc_hi;
      h2 = acc_lo;
      h1 = (h1 ^ (h2 >> mhb_pkg::FIN_SHIFT_1)) * mhb_pkg::MIX_M;
      h2 = (h2 ^ (h1 >> mhb_pkg::FIN_SHIFT_2)) * mhb_pkg::MIX_M;
      h1 = (h1 ^ (h2 >> mhb_pkg::FIN_SHIFT_3)) * mhb_pkg::MIX_M;
      h2 = (h2 ^ (h1 >> mhb_pkg::FIN_SHIFT_4)) * mhb_pkg::MIX_M;
      hash     = {h1, h2};
      acc_hi   = '0;
      acc_lo   = '0;
      lane_odd = 1'b0;
      return 1'b1;
   endfunction

   // idle cycles before the next transaction, with occasional back-to-back runs
   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         run = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   task automatic send_row(stim_row_type r);
      int          gap;
      logic [63:0] hash;
      gap = draw_gap(send_run);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_word    <= r.word;
      req_valid_bytes  <= r.nbytes;
      req_first_word   <= r.first;
      req_last_word    <= r.last;
      req_total_length <= r.length;
      do @(posedge clock); while (req_stall);
      if (fold_item(r, hash)) pending_hashes = {pending_hashes, (r.typed ? r.hash : hash)};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      // transactions that close no message may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_seed     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      hash_seed = value;
   endtask

   task automatic random_phase(int items);
      int           sent;
      int           total;
      int           tail;
      int           count;
      int           i;
      stim_row_type r;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) == 0) begin
            r        = '0;
            r.word   = $urandom;
            r.nbytes = 3'($urandom_range(0, 7));
            r.first  = 1'($urandom_range(0, 1));
            r.last   = 1'($urandom_range(0, 1));
            r.length = $urandom;
            send_row(r);
            sent++;
         end else begin
            total = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 160)
                                                 : $urandom_range(0, 24);
            tail  = total % 4;
            count = total / 4 + ((tail != 0) ? 1 : 0);
            if (count == 0) count = 1;
            for (i = 0; i < count; i++) begin
               r        = '0;
               r.word   = $urandom;
               r.first  = (i == 0);
               r.last   = (i == count - 1);
               r.length = $urandom;
               if (i == 0 && $urandom_range(0, 7) != 0) r.length = total;
               if (i < total / 4) r.nbytes = ($urandom_range(0, 7) == 0)
                                             ? 3'($urandom_range(5, 7)) : 3'd4;
               else r.nbytes = 3'(tail);
               // broken sequences: flipped markers or a stray short word
               case ($urandom_range(0, 59))
                  0: r.first = ~r.first;
                  1: r.last = ~r.last;
                  2: r.nbytes = 3'($urandom_range(1, 3));
                  default: ;
               endcase
               send_row(r);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_seed         <= '0;
      req_valid        <= 1'b0;
      req_data_word    <= '0;
      req_valid_bytes  <= '0;
      req_first_word   <= 1'b0;
      req_last_word    <= 1'b0;
      req_total_length <= '0;
      hash_seed = mhb_pkg::SEED_RESET;
      acc_hi    = '0;
      acc_lo    = '0;
      lane_odd  = 1'b0;
      send_run  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[j]) send_row(directed_rows[j]);
      drain();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: write_seed(32'h0000_0000);
            1: write_seed(32'hFFFF_FFFF);
            default: write_seed($urandom);
         endcase
         random_phase(PHASE_ITEMS);
         drain();
      end
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin : response_side
      int          wait_n;
      bit          held;
      logic [63:0] want;
      held         = 1'b0;
      results_seen = 0;
      recv_run     = 0;
      rsp_stall <= 1'b1;
      @(posedge clock);
      forever begin
         wait_n = draw_gap(recv_run);
         // one long hold-off so the block backs up into its input
         if (!held && results_seen == HOLD_AFTER) begin
            held   = 1'b1;
            wait_n = HOLD_CYCLES;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (pending_hashes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual %h",
                     $time, rsp_hash_value);
         end else begin
            want = pending_hashes.pop_front();
            if (want !== rsp_hash_value) begin
               errors++;
               $display("%0t: hash_value mismatch, expected %h, actual %h",
                        $time, want, rsp_hash_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
